>>> hdl/wed_pkg.sv
// Package with the types and constants of the weighted Euclidean distance block.
`timescale 1ns / 1ps
`default_nettype none

package wed_pkg;

	localparam int FEAT_W     = 16;
	localparam int WEIGHT_W   = 17;
	localparam int DIFF_W     = 17;
	localparam int SQ_W       = 2 * FEAT_W;
	localparam int PROD_W     = WEIGHT_W + SQ_W;
	localparam int FRAC_SHIFT = 16;
	localparam int TERM_W     = PROD_W - FRAC_SHIFT;
	localparam int SUM_W      = 48;
	localparam int DIST_W     = 23;
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int CNT_W      = $clog2(SQRT_STEPS);
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;

	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [SUM_W-1:0] SQRT_BIT0 = {2'b01, {(SUM_W-2){1'b0}}};
	localparam logic [SUM_W-1:0] DIST_MAX  = {{(SUM_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_WT,
		ST_ACC,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hdl/weighted_euclidean_distance_top.sv
// Top level of the weighted Euclidean distance block with its sequencer and shared units.
`timescale 1ns / 1ps
`default_nettype none

// Each input item carries one feature pair, its weight and a last-of-vector mark, and yields one
// result item with the difference test minus reference. A single shared 17 x 32 multiplier forms
// the square and then the weighted square; no new item is taken until the result of the last one
// is loaded. An item marked last also runs the restoring square root of the 48-bit saturating sum,
// two bits per cycle. The result sits in an output register; the block accepts the next item while
// that result still waits.
module weighted_euclidean_distance_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// s_tdata from bit 0: test_value[15:0], ref_value[15:0], weight[16:0], zero fill.
	input  wire logic [wed_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// m_tdata from bit 0: difference[16:0], distance[22:0].
	output logic [wed_pkg::OUT_TDATA_W-1:0]          m_tdata,
	// m_tuser: distance_valid.
	output logic                                     m_tuser
);

	wed_pkg::state_t state_q, state_d;

	logic [wed_pkg::FEAT_W-1:0]   mag_q;
	logic [wed_pkg::WEIGHT_W-1:0] weight_q;
	logic [wed_pkg::DIFF_W-1:0]   diff_q;
	logic                         last_q;
	logic [wed_pkg::PROD_W-1:0]   prod_q;
	logic [wed_pkg::SUM_W-1:0]    sum_q;
	logic [wed_pkg::SUM_W-1:0]    rem_q;
	logic [wed_pkg::SUM_W-1:0]    root_q;
	logic [wed_pkg::SUM_W-1:0]    bit_q;
	logic [wed_pkg::CNT_W-1:0]    cnt_q;

	logic [wed_pkg::DIFF_W-1:0]   out_diff_q;
	logic [wed_pkg::DIST_W-1:0]   out_dist_q;
	logic                         out_flag_q;
	logic                         out_valid_q;

	logic [wed_pkg::FEAT_W-1:0]   in_test;
	logic [wed_pkg::FEAT_W-1:0]   in_ref;
	logic [wed_pkg::WEIGHT_W-1:0] in_weight;
	logic                         accept;
	logic                         load_out;
	logic                         sel_weight;
	logic [wed_pkg::WEIGHT_W-1:0] mul_a;
	logic [wed_pkg::SQ_W-1:0]     mul_b;
	logic [wed_pkg::PROD_W-1:0]   mul_p;
	logic [wed_pkg::TERM_W-1:0]   term;
	logic [wed_pkg::SUM_W:0]      sum_wide;
	logic [wed_pkg::SUM_W-1:0]    sum_next;
	logic [wed_pkg::SUM_W-1:0]    trial;
	logic                         trial_ok;
	logic [wed_pkg::DIST_W-1:0]   dist_sat;

	assign in_test   = s_tdata[wed_pkg::FEAT_W-1:0];
	assign in_ref    = s_tdata[2*wed_pkg::FEAT_W-1:wed_pkg::FEAT_W];
	assign in_weight = s_tdata[2*wed_pkg::FEAT_W+wed_pkg::WEIGHT_W-1:2*wed_pkg::FEAT_W];

	assign accept = s_tvalid && s_tready;

	assign mul_a = sel_weight ? weight_q : {1'b0, mag_q};
	assign mul_b = sel_weight ? prod_q[wed_pkg::SQ_W-1:0]
		: {{(wed_pkg::SQ_W-wed_pkg::FEAT_W){1'b0}}, mag_q};
	assign mul_p = {{wed_pkg::SQ_W{1'b0}}, mul_a} * {{wed_pkg::WEIGHT_W{1'b0}}, mul_b};

	assign term     = prod_q[wed_pkg::PROD_W-1:wed_pkg::FRAC_SHIFT];
	assign sum_wide = {1'b0, sum_q}
		+ {{(wed_pkg::SUM_W+1-wed_pkg::TERM_W){1'b0}}, term};
	assign sum_next = sum_wide[wed_pkg::SUM_W] ? wed_pkg::SUM_MAX : sum_wide[wed_pkg::SUM_W-1:0];

	assign trial    = root_q + bit_q;
	assign trial_ok = rem_q >= trial;
	assign dist_sat = (root_q > wed_pkg::DIST_MAX) ? {wed_pkg::DIST_W{1'b1}}
		: root_q[wed_pkg::DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wed_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		sel_weight = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			wed_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = wed_pkg::ST_SQ;
				end
			end
			wed_pkg::ST_SQ: begin
				state_d = wed_pkg::ST_WT;
			end
			wed_pkg::ST_WT: begin
				sel_weight = 1'b1;
				state_d    = wed_pkg::ST_ACC;
			end
			wed_pkg::ST_ACC: begin
				state_d = last_q ? wed_pkg::ST_ROOT : wed_pkg::ST_DONE;
			end
			wed_pkg::ST_ROOT: begin
				if (cnt_q == wed_pkg::CNT_W'(wed_pkg::SQRT_STEPS - 1)) begin
					state_d = wed_pkg::ST_DONE;
				end
			end
			wed_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = wed_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wed_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				wed_pkg::ST_ACC: begin
					cnt_q <= '0;
					sum_q <= last_q ? '0 : sum_next;
				end
				wed_pkg::ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q    <= (in_test >= in_ref) ? (in_test - in_ref) : (in_ref - in_test);
			weight_q <= in_weight;
			diff_q   <= {1'b0, in_test} - {1'b0, in_ref};
			last_q   <= s_tlast;
		end
		if (state_q == wed_pkg::ST_SQ || state_q == wed_pkg::ST_WT) begin
			prod_q <= mul_p;
		end
		if (state_q == wed_pkg::ST_ACC) begin
			rem_q  <= sum_next;
			root_q <= '0;
			bit_q  <= wed_pkg::SQRT_BIT0;
		end
		if (state_q == wed_pkg::ST_ROOT) begin
			if (trial_ok) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (load_out) begin
			out_diff_q <= diff_q;
			out_dist_q <= last_q ? dist_sat : '0;
			out_flag_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_dist_q, out_diff_q};
	assign m_tuser  = out_flag_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == wed_pkg::ST_SQ)
		else $error("accepted item did not start the square step");

	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wed_pkg::ST_ACC && last_q) |=> sum_q == '0)
		else $error("sum not cleared after the last feature");

	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wed_pkg::ST_ROOT |-> cnt_q < wed_pkg::CNT_W'(wed_pkg::SQRT_STEPS))
		else $error("square root step count out of range");

	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> out_dist_q == '0)
		else $error("distance not zero on a result without a distance");
`endif

endmodule

`default_nettype wire

>>> dv/weighted_euclidean_distance_top_test.sv
// Self-checking testbench for the weighted Euclidean distance block with a predictor and random stalls.
`timescale 1ns / 1ps

module weighted_euclidean_distance_top_test;

	typedef struct {
		logic [wed_pkg::DIFF_W-1:0] difference;
		logic [wed_pkg::DIST_W-1:0] distance;
		logic                       distance_valid;
	} distance_result_t;

	localparam logic [wed_pkg::FEAT_W-1:0]   FEAT_TOP       = {wed_pkg::FEAT_W{1'b1}};
	localparam logic [wed_pkg::WEIGHT_W-1:0] WEIGHT_ONE     = 17'h10000;
	localparam logic [wed_pkg::WEIGHT_W-1:0] WEIGHT_TOP     = {wed_pkg::WEIGHT_W{1'b1}};
	localparam int                           IDLE_PERCENT   = 26;
	localparam int                           HEAVY_FEATURES = 120;
	localparam int                           RANDOM_ITEMS   = 1180;
	localparam int                           STALL_CYCLES   = 400;
	localparam int                           DRAIN_CYCLES   = 60;
	localparam int                           REPORT_LIMIT   = 10;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [wed_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            s_tlast  = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [wed_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tuser;

	logic [wed_pkg::SUM_W-1:0] feature_sum = '0;
	distance_result_t          pending_results[$];
	int                        mismatches      = 0;
	bit                        idle_enable     = 1'b1;
	int                        rx_hold_request = 0;
	int                        rx_hold_left    = 0;

	always #5 clk = ~clk;

	weighted_euclidean_distance_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic distance_result_t weigh_feature(
			input logic [wed_pkg::FEAT_W-1:0] test_value,
			input logic [wed_pkg::FEAT_W-1:0] ref_value,
			input logic [wed_pkg::WEIGHT_W-1:0] weight,
			input logic is_last);
		distance_result_t res;
		logic [wed_pkg::FEAT_W-1:0] magnitude;
		logic [63:0]                term;
		logic [63:0]                total;
		logic [63:0]                root;
		logic [63:0]                trial;
		int                         bit_pos;
		magnitude = (test_value >= ref_value) ? test_value - ref_value : ref_value - test_value;
		term = (64'(weight) * (64'(magnitude) * 64'(magnitude))) >> wed_pkg::FRAC_SHIFT;
		total = 64'(feature_sum) + term;
		feature_sum = (total > 64'(wed_pkg::SUM_MAX)) ? wed_pkg::SUM_MAX
			: total[wed_pkg::SUM_W-1:0];
		res.difference = {1'b0, test_value} - {1'b0, ref_value};
		res.distance = '0;
		res.distance_valid = is_last;
		if (is_last) begin
			root = '0;
			for (bit_pos = wed_pkg::SUM_W / 2 - 1; bit_pos >= 0; bit_pos--) begin
				trial = root | (64'(1) << bit_pos);
				if (trial * trial <= 64'(feature_sum)) begin
					root = trial;
				end
			end
			res.distance = (root > 64'(wed_pkg::DIST_MAX))
				? wed_pkg::DIST_MAX[wed_pkg::DIST_W-1:0] : root[wed_pkg::DIST_W-1:0];
			feature_sum = '0;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		distance_result_t wanted;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("Unexpected result item: tdata %h tuser %b", m_tdata, m_tuser);
				end
			end else begin
				wanted = pending_results.pop_front();
				if (m_tdata[wed_pkg::DIFF_W-1:0] !== wanted.difference
						|| m_tdata[wed_pkg::DIFF_W+wed_pkg::DIST_W-1:wed_pkg::DIFF_W]
						!== wanted.distance
						|| m_tuser !== wanted.distance_valid) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("Mismatch: expected diff %h dist %h valid %b, %s",
							wanted.difference, wanted.distance, wanted.distance_valid,
							$sformatf("got diff %h dist %h valid %b",
							m_tdata[wed_pkg::DIFF_W-1:0],
							m_tdata[wed_pkg::DIFF_W+wed_pkg::DIST_W-1:wed_pkg::DIFF_W],
							m_tuser));
					end
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			pending_results.insert(pending_results.size(),
				weigh_feature(s_tdata[wed_pkg::FEAT_W-1:0],
				s_tdata[2*wed_pkg::FEAT_W-1:wed_pkg::FEAT_W],
				s_tdata[2*wed_pkg::FEAT_W+wed_pkg::WEIGHT_W-1:2*wed_pkg::FEAT_W], s_tlast));
		end
	end

	always @(posedge clk) begin
		if (rx_hold_request != 0) begin
			rx_hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left = rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !idle_enable || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	task automatic send_feature(input logic [wed_pkg::FEAT_W-1:0] test_value,
			input logic [wed_pkg::FEAT_W-1:0] ref_value,
			input logic [wed_pkg::WEIGHT_W-1:0] weight,
			input logic is_last);
		while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(wed_pkg::IN_TDATA_W-2*wed_pkg::FEAT_W-wed_pkg::WEIGHT_W){1'b0}},
			weight, ref_value, test_value};
		s_tlast <= is_last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [wed_pkg::FEAT_W-1:0] pick_feature();
		case ($urandom_range(9))
			0: return '0;
			1: return FEAT_TOP;
			default: return wed_pkg::FEAT_W'($urandom);
		endcase
	endfunction

	function automatic logic [wed_pkg::WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return WEIGHT_ONE;
			2: return WEIGHT_TOP;
			3, 4: return wed_pkg::WEIGHT_W'($urandom_range(0, WEIGHT_ONE));
			default: return wed_pkg::WEIGHT_W'($urandom_range(0, WEIGHT_TOP));
		endcase
	endfunction

	task automatic send_random_vector(input int length);
		for (int i = 0; i < length; i++) begin
			send_feature(pick_feature(), pick_feature(), pick_weight(), i == length - 1);
		end
	endtask

	task automatic test_directed_features();
		send_feature(FEAT_TOP, '0, WEIGHT_ONE, 1'b1);
		send_feature('0, FEAT_TOP, WEIGHT_ONE, 1'b1);
		send_feature('0, '0, '0, 1'b1);
		send_feature(16'd12345, 16'd12345, WEIGHT_TOP, 1'b1);
		send_feature(FEAT_TOP, '0, '0, 1'b1);
		send_feature(FEAT_TOP, '0, WEIGHT_TOP, 1'b1);
		send_feature('0, FEAT_TOP, WEIGHT_ONE - 1, 1'b1);
		send_feature(16'd1, 16'd0, 17'd1, 1'b1);
		send_feature(16'h8000, 16'h7FFF, WEIGHT_ONE, 1'b0);
		send_feature(16'h1234, 16'hABCD, 17'h0AAAA, 1'b0);
		send_feature(16'hFFFE, 16'h0001, 17'h15555, 1'b0);
		send_feature(16'h5555, 16'hAAAA, WEIGHT_TOP, 1'b1);
		send_feature(FEAT_TOP, '0, WEIGHT_TOP, 1'b0);
		send_feature('0, FEAT_TOP, WEIGHT_TOP, 1'b0);
		send_feature(FEAT_TOP, '0, WEIGHT_TOP, 1'b1);
		send_feature(16'h00FF, 16'hFF00, WEIGHT_ONE, 1'b1);
	endtask

	// The receiver stops for a long stretch so the output register and then the input fill up.
	task automatic test_output_stall();
		rx_hold_request = STALL_CYCLES;
		for (int i = 0; i < 8; i++) begin
			send_random_vector($urandom_range(1, 5));
		end
	endtask

	// A long vector of the heaviest features, sent with no idling on either side.
	task automatic test_heavy_vector();
		idle_enable = 1'b0;
		for (int i = 0; i < HEAVY_FEATURES; i++) begin
			if (i % 2 == 0) begin
				send_feature(FEAT_TOP, '0, WEIGHT_TOP, i == HEAVY_FEATURES - 1);
			end else begin
				send_feature('0, FEAT_TOP, WEIGHT_TOP, i == HEAVY_FEATURES - 1);
			end
		end
		idle_enable = 1'b1;
		send_feature(16'd3, 16'd1, WEIGHT_ONE, 1'b1);
	endtask

	task automatic test_pause_until_drained();
		send_random_vector(3);
		wait_for_results();
		send_random_vector(1);
		send_random_vector(4);
	endtask

	task automatic test_random_vectors();
		int sent;
		int pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				pick = $urandom_range(1, 8);
			end else if (pick < 95) begin
				pick = $urandom_range(9, 40);
			end else begin
				pick = $urandom_range(41, 120);
			end
			send_random_vector(pick);
			sent += pick;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_features();
		test_output_stall();
		test_heavy_vector();
		test_pause_until_drained();
		test_random_vectors();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("weighted_euclidean_distance_top_test OK");
		end else begin
			$display("weighted_euclidean_distance_top_test NOT OK");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("weighted_euclidean_distance_top_test NOT OK");
		$finish;
	end

endmodule
